// File: rtl/core/sobel_gradient_edge_stream_assert.svh
// ---------------------------------------------------------------------------
// Sobel gradient edge stream: assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef SOBEL_GRADIENT_EDGE_STREAM_ASSERT_SVH
`define SOBEL_GRADIENT_EDGE_STREAM_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SGE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define SGE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/sge_pkg.sv
// ---------------------------------------------------------------------------
// sge_pkg
// Types, constants and helper functions of the Sobel gradient edge stream.
// ---------------------------------------------------------------------------
package sge_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int PIX_W       = 8;
  localparam int WIDTH_CFG_W = 11;
  localparam int THRESH_W    = 8;
  localparam int CFG_DATA_W  = 11;
  localparam int CFG_IDX_W   = 2;

  localparam logic [WIDTH_CFG_W-1:0] WIDTH_RST  = 11'd640;
  localparam logic [THRESH_W-1:0]    THRESH_RST = 8'd30;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_THRESH = 2'd1;

  localparam logic [PIX_W-1:0] BIAS = 8'd128;

  // 3-row window column, index 0 is the top row
  typedef logic [2:0][PIX_W-1:0] pix3_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SQ,
    S_SQRT,
    S_OUT
  } sge_state_t;

  // biased gradients of one position
  typedef struct packed {
    logic [PIX_W-1:0] xb;
    logic [PIX_W-1:0] yb;
  } grad_t;

  function automatic logic [9:0] wsum(logic [7:0] p0, logic [7:0] p1, logic [7:0] p2);
    wsum = {2'b00, p0} + {1'b0, p1, 1'b0} + {2'b00, p2};
  endfunction

  // (pos - neg + 1024) >> 3, always within 0..255
  function automatic logic [7:0] bias_diff(logic [9:0] pos, logic [9:0] neg);
    logic [11:0] s;
    s = {2'b00, pos} + 12'd1024 - {2'b00, neg};
    bias_diff = s[10:3];
  endfunction

  function automatic grad_t sobel(pix3_t l, pix3_t m, pix3_t r);
    grad_t g;
    g.xb = bias_diff(wsum(r[0], r[1], r[2]), wsum(l[0], l[1], l[2]));
    g.yb = bias_diff(wsum(l[2], m[2], r[2]), wsum(l[0], m[0], r[0]));
    sobel = g;
  endfunction

  // |v - 128|, 0..128
  function automatic logic [7:0] unbias(logic [7:0] v);
    unbias = v[7] ? (v - BIAS) : (BIAS - v);
  endfunction

endpackage

// File: rtl/core/sge_ram.sv
// ---------------------------------------------------------------------------
// sge_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module sge_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/sobel_gradient_edge_stream.sv
// ---------------------------------------------------------------------------
// sobel_gradient_edge_stream
// Streaming 3x3 Sobel gradient magnitude and edge flag over two line stores.
// ---------------------------------------------------------------------------
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_ready   in_cmd, in_pixel
//   out_     output     out_valid / out_ready gradients, magnitude, flags
//   cfg_     input      cfg_we                cfg_index, cfg_data
//
// One transaction at a time. An input transaction passes through accept and
// line store read, then for each of its zero, one or two results through
// square, 8 root steps of the bit-serial square root and output. A stalled
// output holds the block; in_ready is high only when no transaction is in
// progress.
// Synchronous reset clears control state and the window; the line stores
// are not cleared and need no clearing pass.
//
// The block keeps the two previous rows in two RAMs read at the current
// column. In the cycle after the read the window column is formed, the stores
// are written back at the same column and the gradients of the one or two
// results are latched. Read and write of one column never overlap, since the
// next read comes only after the write-back.
// ---------------------------------------------------------------------------
`include "sobel_gradient_edge_stream_assert.svh"

module sobel_gradient_edge_stream
  import sge_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // input transactions
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_cmd,
  input  logic [PIX_W-1:0]      in_pixel,
  // result transactions
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [PIX_W-1:0]      out_grad_x_biased,
  output logic [PIX_W-1:0]      out_grad_y_biased,
  output logic [PIX_W-1:0]      out_magnitude,
  output logic                  out_is_edge,
  output logic                  out_last_in_run,
  output logic                  out_frame_done,
  // configuration writes
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  sge_state_t state_r, state_nxt;

  // configuration
  logic [WIDTH_CFG_W-1:0] width_r;
  logic [THRESH_W-1:0]    thresh_r;

  // frame position and window
  logic [COL_W-1:0] col_r;
  logic [1:0]       rows_r;     // 0 none, 1 one row, 2 two or more
  pix3_t            win0_r, win1_r;

  // current transaction
  logic [COL_W-1:0] c_r;
  logic             last_r;
  logic             flush_r;
  logic [PIX_W-1:0] pix_r;

  // pending results
  grad_t grad0_r, grad1_r;
  logic  has1_r;
  logic  sel_r;
  logic  frame1_r;

  // square root unit
  logic [15:0]      v_r;
  logic [PIX_W-1:0] root_r;
  logic [PIX_W-1:0] bit_r;

  // output register
  logic [PIX_W-1:0] out_xb_r, out_yb_r, out_mag_r;
  logic             out_edge_r, out_last_r, out_frame_r;

  // line stores
  logic [PIX_W-1:0] older_rd, recent_rd;
  logic             ram_we, ram_re;

  // effective width and clamped column
  logic [COL_W:0]   w_eff;
  logic [COL_W-1:0] last_col;
  logic [COL_W-1:0] c_clamp;
  logic             accept, skip;

  always_comb begin
    if (width_r == '0) begin
      w_eff = (COL_W+1)'(1);
    end else if (int'(width_r) > MAX_WIDTH) begin
      w_eff = (COL_W+1)'(MAX_WIDTH);
    end else begin
      w_eff = (COL_W+1)'(width_r);
    end
    last_col = COL_W'(w_eff - 1'b1);
    c_clamp  = ({1'b0, col_r} >= w_eff) ? last_col : col_r;
  end

  assign accept = in_valid && in_ready;
  // a flush before any row changes nothing
  assign skip   = in_cmd && (rows_r == 2'd0);
  assign ram_re = accept;
  assign ram_we = (state_r == S_READ) && !flush_r;

  sge_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_older_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (c_r),
    .wdata (recent_rd),
    .re    (ram_re),
    .raddr (c_clamp),
    .rdata (older_rd)
  );

  sge_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_recent_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (c_r),
    .wdata (pix_r),
    .re    (ram_re),
    .raddr (c_clamp),
    .rdata (recent_rd)
  );

  // window column and the two candidate results
  pix3_t cur;
  pix3_t left0, left1;
  logic  has0;

  always_comb begin
    if (rows_r == 2'd0) begin
      cur = {pix_r, pix_r, pix_r};
    end else begin
      cur[0] = (rows_r == 2'd1) ? recent_rd : older_rd;
      cur[1] = recent_rd;
      cur[2] = flush_r ? recent_rd : pix_r;
    end
    left0 = (c_r >= COL_W'(2)) ? win1_r : win0_r;
    left1 = (c_r >= COL_W'(1)) ? win0_r : cur;
    has0  = (rows_r != 2'd0) && (c_r >= COL_W'(1));
  end

  // square root step: try the next bit
  logic [PIX_W-1:0] trial;
  logic [15:0]      trial_sq;
  logic [PIX_W-1:0] root_step;
  grad_t            grad_sel;
  logic [PIX_W-1:0] ax, ay;

  always_comb begin
    trial     = root_r | bit_r;
    trial_sq  = trial * trial;
    root_step = (trial_sq <= v_r) ? trial : root_r;
    grad_sel  = sel_r ? grad1_r : grad0_r;
    ax        = unbias(grad_sel.xb);
    ay        = unbias(grad_sel.yb);
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and handshake outputs
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && !skip) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        if (has0 || ((rows_r != 2'd0) && last_r)) begin
          state_nxt = S_SQ;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_SQ: begin
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        if (bit_r[0]) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = (!sel_r && has1_r) ? S_SQ : S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      thresh_r <= THRESH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH: width_r  <= cfg_data[WIDTH_CFG_W-1:0];
        REG_EDGE_THRESH: thresh_r <= cfg_data[THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  // frame position and window
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      rows_r <= 2'd0;
      win0_r <= '0;
      win1_r <= '0;
    end else if (state_r == S_READ) begin
      win1_r <= win0_r;
      win0_r <= cur;
      if (last_r) begin
        col_r <= '0;
        if (flush_r) begin
          rows_r <= 2'd0;
        end else if (rows_r != 2'd2) begin
          rows_r <= rows_r + 2'd1;
        end
      end else begin
        col_r <= c_r + 1'b1;
      end
    end
  end

  // transaction, result and root datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          c_r     <= c_clamp;
          last_r  <= (c_clamp == last_col);
          flush_r <= in_cmd;
          pix_r   <= in_pixel;
        end
      end
      S_READ: begin
        grad0_r  <= sobel(left0, win0_r, cur);
        grad1_r  <= sobel(left1, cur, cur);
        has1_r   <= (rows_r != 2'd0) && last_r;
        frame1_r <= flush_r;
        sel_r    <= !has0;
      end
      S_SQ: begin
        v_r    <= (ax * ax) + (ay * ay);
        root_r <= '0;
        bit_r  <= {1'b1, {(PIX_W-1){1'b0}}};
      end
      S_SQRT: begin
        root_r <= root_step;
        bit_r  <= bit_r >> 1;
        if (bit_r[0]) begin
          out_xb_r    <= grad_sel.xb;
          out_yb_r    <= grad_sel.yb;
          out_mag_r   <= root_step;
          out_edge_r  <= (root_step >= thresh_r);
          out_last_r  <= sel_r || !has1_r;
          out_frame_r <= sel_r && frame1_r;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          sel_r <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_grad_x_biased = out_xb_r;
  assign out_grad_y_biased = out_yb_r;
  assign out_magnitude     = out_mag_r;
  assign out_is_edge       = out_edge_r;
  assign out_last_in_run   = out_last_r;
  assign out_frame_done    = out_frame_r;

  // the two sides never hold a transaction at once
  `SGE_ASSERT_NOW(a_no_overlap, in_ready, !out_valid, "input taken while a result is pending")
  // end of frame only on the last result of the flush transaction
  `SGE_ASSERT_NOW(a_frame_last, out_valid && out_frame_done, out_last_in_run,
                  "frame_done without last_in_run")
  // magnitude never exceeds the root of 2*128^2
  `SGE_ASSERT_NOW(a_mag_range, out_valid, out_magnitude <= 8'd181, "magnitude out of range")
  // a line store write follows every accepted pixel transaction
  `SGE_ASSERT_NEXT(a_store_write, accept && !in_cmd, ram_we, "pixel not written back")

endmodule
